### rtl/transformed_bounds_builder_core_macros.svh
`ifndef TRANSFORMED_BOUNDS_BUILDER_CORE_MACROS_SVH
`define TRANSFORMED_BOUNDS_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TBB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbb check failed");

// Next-cycle implication, checked outside reset
`define TBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbb check failed");

`endif

### rtl/tbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbb_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // request commands
   localparam logic [2:0] CMD_TRANSLATION = 3'd0;
   localparam logic [2:0] CMD_ROTATION    = 3'd1;
   localparam logic [2:0] CMD_SCALE       = 3'd2;
   localparam logic [2:0] CMD_BOX_LOW     = 3'd3;
   localparam logic [2:0] CMD_BOX_HIGH    = 3'd4;
   localparam logic [2:0] CMD_COMPUTE     = 3'd5;

   localparam logic signed [31:0] ONE_Q   = 32'sh0001_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   // angles in Q16 degrees
   localparam logic [31:0]        PERIOD_Q = 32'd23592960;
   localparam logic signed [26:0] DEG90    = 27'sd5898240;
   localparam logic signed [26:0] DEG180   = 27'sd11796480;
   localparam logic signed [26:0] DEG360   = 27'sd23592960;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
      logic signed [31:0] sphere_center_x;
      logic signed [31:0] sphere_center_y;
      logic signed [31:0] sphere_center_z;
      logic signed [31:0] sphere_radius;
   } rsp_type;

   // one multiply-accumulate operation for a lane
   typedef struct packed {
      logic               issue;
      logic               first;
      logic signed [31:0] init;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mac_op_type;

   // arctangent of 2^-i in Q16 degrees
   function automatic logic signed [26:0] atan_q16(input logic [3:0] idx);
      logic signed [26:0] v;
      begin
         unique case (idx)
            4'd0:    v = 27'sd2949120;
            4'd1:    v = 27'sd1740967;
            4'd2:    v = 27'sd919879;
            4'd3:    v = 27'sd466945;
            4'd4:    v = 27'sd234379;
            4'd5:    v = 27'sd117304;
            4'd6:    v = 27'sd58666;
            4'd7:    v = 27'sd29335;
            4'd8:    v = 27'sd14668;
            4'd9:    v = 27'sd7334;
            4'd10:   v = 27'sd3667;
            4'd11:   v = 27'sd1833;
            4'd12:   v = 27'sd917;
            4'd13:   v = 27'sd458;
            4'd14:   v = 27'sd229;
            default: v = 27'sd115;
         endcase
         return v;
      end
   endfunction

   // fixed-point product: magnitude truncated, sign applied, saturated
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic [31:0] ua;
      logic [31:0] ub;
      logic        neg;
      logic [63:0] pr;
      logic [47:0] m;
      logic [47:0] lim;
      logic signed [31:0] r;
      begin
         ua  = a[31] ? 32'(-a) : 32'(a);
         ub  = b[31] ? 32'(-b) : 32'(b);
         neg = a[31] ^ b[31];
         pr  = {32'd0, ua} * {32'd0, ub};
         m   = pr[63:16];
         lim = neg ? 48'h0000_8000_0000 : 48'h0000_7fff_ffff;
         if (m > lim) begin
            r = neg ? WORD_MIN : WORD_MAX;
         end else if (neg) begin
            r = 32'(-m[31:0]);
         end else begin
            r = m[31:0];
         end
         return r;
      end
   endfunction

   // saturating add
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      logic signed [31:0] r;
      begin
         s = 33'(a) + 33'(b);
         if (s > 33'(WORD_MAX)) begin
            r = WORD_MAX;
         end else if (s < 33'(WORD_MIN)) begin
            r = WORD_MIN;
         end else begin
            r = s[31:0];
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/tbb_cordic_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tbb_cordic_lane (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] angle,
   output logic                    done,
   output logic signed [31:0]      sin_out,
   output logic signed [31:0]      cos_out
);

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_RED  = 3'd1;
   localparam logic [2:0] L_FOLD = 3'd2;
   localparam logic [2:0] L_ROT  = 3'd3;
   localparam logic [2:0] L_FIN  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               flip_ff, flip_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [26:0] z_ff, z_in;
   logic               done_ff, done_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [31:0] cos_ff, cos_in;

   logic [31:0]        red_lim;
   logic [31:0]        red_r;
   logic signed [26:0] z0;
   logic signed [33:0] xf;
   logic signed [33:0] xs;
   logic signed [33:0] ys;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      flip_in  = flip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      done_in  = 1'b0;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      red_lim  = tbb_pkg::PERIOD_Q << cnt_ff[2:0];
      red_r    = (neg_ff && (mag_ff != 32'd0)) ? (tbb_pkg::PERIOD_Q - mag_ff) : mag_ff;
      z0       = $signed({2'b00, red_r[24:0]});
      xs       = x_ff >>> cnt_ff;
      ys       = y_ff >>> cnt_ff;
      xf       = flip_ff ? -x_ff : x_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               mag_in   = angle[31] ? 32'(-angle) : 32'(angle);
               neg_in   = angle[31];
               cnt_in   = 4'd6;
               state_in = L_RED;
            end
         end
         // remainder by the period, one shifted multiple a cycle
         L_RED: begin
            if (mag_ff >= red_lim) begin
               mag_in = mag_ff - red_lim;
            end
            if (cnt_ff == 4'd0) begin
               state_in = L_FOLD;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         // fold into [-90, 90] degrees
         L_FOLD: begin
            if (z0 >= tbb_pkg::DEG180) begin
               z0 = z0 - tbb_pkg::DEG360;
            end
            flip_in = 1'b1;
            if (z0 > tbb_pkg::DEG90) begin
               z_in = tbb_pkg::DEG180 - z0;
            end else if (z0 < -tbb_pkg::DEG90) begin
               z_in = -tbb_pkg::DEG180 - z0;
            end else begin
               z_in    = z0;
               flip_in = 1'b0;
            end
            x_in     = tbb_pkg::GAIN_Q30;
            y_in     = 34'sd0;
            cnt_in   = 4'd0;
            state_in = L_ROT;
         end
         // one rotation per cycle
         L_ROT: begin
            if (z_ff >= 27'sd0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - tbb_pkg::atan_q16(cnt_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + tbb_pkg::atan_q16(cnt_ff);
            end
            if (cnt_ff == 4'd15) begin
               state_in = L_FIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         // Q30 to Q16, round half up
         L_FIN: begin
            cos_in   = 32'((xf + 34'sd8192) >>> 14);
            sin_in   = 32'((y_ff + 34'sd8192) >>> 14);
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign done    = done_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

### rtl/tbb_mac_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tbb_mac_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbb_pkg::mac_op_type  op,
   output logic signed [31:0]        acc
);

   logic               v_ff;
   logic               first_ff;
   logic signed [31:0] init_ff;
   logic signed [31:0] p_ff;
   logic signed [31:0] acc_ff, acc_in;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= op.issue;
      end
      first_ff <= op.first;
      init_ff  <= op.init;
      p_ff     <= tbb_pkg::mulq(op.a, op.b);
   end

   // saturating accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (v_ff) begin
         acc_in = tbb_pkg::sat_add(first_ff ? init_ff : acc_ff, p_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### rtl/transformed_bounds_builder_core.sv
// Load requests (commands 0..4) store their vector; busy stays low.
// A compute request holds busy while the three parallel sine/cosine
// lanes run and then through 23 steps on the three multiply-accumulate
// lanes. rsp_valid pulses once at the end.
// Requests are not accepted while busy, so computes do not overlap.
// Synchronous active-high reset clears the five loaded vectors and control.
`timescale 1ns / 1ps
`default_nettype none

module transformed_bounds_builder_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tbb_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tbb_pkg::rsp_type      rsp_data
);

`include "transformed_bounds_builder_core_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TRIG = 2'd1;
   localparam logic [1:0] S_MAC  = 2'd2;

   localparam logic [4:0] STEP_R      = 5'd3;
   localparam logic [4:0] STEP_CORNER = 5'd6;
   localparam logic [4:0] STEP_RADIUS = 5'd22;

   logic [1:0] state_ff;
   logic [4:0] step_ff;
   logic [2:0] sub_ff;

   logic signed [31:0] trans_ff [3];
   logic signed [31:0] rot_ff   [3];
   logic signed [31:0] scale_ff [3];
   logic signed [31:0] low_ff   [3];
   logic signed [31:0] high_ff  [3];
   logic signed [31:0] radius_ff;
   logic signed [31:0] rxy_ff [3][3];
   logic signed [31:0] rm_ff  [3][3];
   logic signed [31:0] q_ff   [3];
   logic signed [31:0] lo_ff  [3];
   logic signed [31:0] hi_ff  [3];
   logic               rsp_valid_ff;
   tbb_pkg::rsp_type   rsp_ff;

   logic               accept;
   logic               go;
   logic [2:0]         lane_done;
   logic signed [31:0] sn [3];
   logic signed [31:0] cs [3];
   logic signed [31:0] rx [3][3];
   logic signed [31:0] ry [3][3];
   logic signed [31:0] rz [3][3];
   logic signed [31:0] smax;
   logic signed [31:0] acc [3];
   tbb_pkg::mac_op_type ops [3];
   logic [4:0]         cstep;
   logic [2:0]         kk;
   logic [1:0]         col;
   logic [1:0]         si;

   assign accept = start && !busy;
   assign go     = accept && (req_data.command == tbb_pkg::CMD_COMPUTE);
   assign busy   = (state_ff != S_IDLE);

   // sine/cosine lanes, one per axis
   for (genvar g = 0; g < 3; g++) begin : g_cordic
      tbb_cordic_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (go),
         .angle   (rot_ff[g]),
         .done    (lane_done[g]),
         .sin_out (sn[g]),
         .cos_out (cs[g])
      );
   end

   // elementary rotation matrices
   always_comb begin
      rx[0][0] = tbb_pkg::ONE_Q; rx[0][1] = '0;     rx[0][2] = '0;
      rx[1][0] = '0;             rx[1][1] = cs[0];  rx[1][2] = -sn[0];
      rx[2][0] = '0;             rx[2][1] = sn[0];  rx[2][2] = cs[0];
      ry[0][0] = cs[1];  ry[0][1] = '0;             ry[0][2] = sn[1];
      ry[1][0] = '0;     ry[1][1] = tbb_pkg::ONE_Q; ry[1][2] = '0;
      ry[2][0] = -sn[1]; ry[2][1] = '0;             ry[2][2] = cs[1];
      rz[0][0] = cs[2];  rz[0][1] = -sn[2]; rz[0][2] = '0;
      rz[1][0] = sn[2];  rz[1][1] = cs[2];  rz[1][2] = '0;
      rz[2][0] = '0;     rz[2][1] = '0;     rz[2][2] = tbb_pkg::ONE_Q;
   end

   // largest scale component
   always_comb begin
      smax = scale_ff[0];
      if (scale_ff[1] > smax) begin
         smax = scale_ff[1];
      end
      if (scale_ff[2] > smax) begin
         smax = scale_ff[2];
      end
   end

   // step decode
   always_comb begin
      cstep = step_ff - STEP_CORNER;
      kk    = cstep[3:1];
      si    = sub_ff[1:0];
      if (step_ff < STEP_R) begin
         col = step_ff[1:0];
      end else begin
         col = 2'(step_ff - STEP_R);
      end
   end

   // operand select for the three MAC lanes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ops[i].issue = 1'b0;
         ops[i].first = (sub_ff == 3'd0);
         ops[i].init  = '0;
         ops[i].a     = '0;
         ops[i].b     = '0;
         if (state_ff == S_MAC && sub_ff < 3'd3) begin
            priority if (step_ff < STEP_R) begin
               ops[i].issue = 1'b1;
               ops[i].a     = rx[i][si];
               ops[i].b     = ry[si][col];
            end else if (step_ff < STEP_CORNER) begin
               ops[i].issue = 1'b1;
               ops[i].a     = rxy_ff[i][si];
               ops[i].b     = rz[si][col];
            end else if (step_ff == STEP_RADIUS) begin
               ops[i].issue = (i == 0) && (sub_ff == 3'd0);
               ops[i].a     = radius_ff;
               ops[i].b     = smax;
            end else if (!cstep[0]) begin
               ops[i].issue = (sub_ff == 3'd0);
               ops[i].a     = scale_ff[i];
               ops[i].b     = kk[i] ? high_ff[i] : low_ff[i];
            end else begin
               ops[i].issue = 1'b1;
               ops[i].init  = trans_ff[i];
               ops[i].a     = rm_ff[i][si];
               ops[i].b     = q_ff[si];
            end
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_mac
      tbb_mac_lane u_mac (
         .clock (clock),
         .reset (reset),
         .op    (ops[g]),
         .acc   (acc[g])
      );
   end

   // control and stored vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            trans_ff[i] <= '0;
            rot_ff[i]   <= '0;
            scale_ff[i] <= '0;
            low_ff[i]   <= '0;
            high_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (accept) begin
            unique case (req_data.command)
               tbb_pkg::CMD_TRANSLATION: begin
                  trans_ff[0] <= req_data.value_x;
                  trans_ff[1] <= req_data.value_y;
                  trans_ff[2] <= req_data.value_z;
               end
               tbb_pkg::CMD_ROTATION: begin
                  rot_ff[0] <= req_data.value_x;
                  rot_ff[1] <= req_data.value_y;
                  rot_ff[2] <= req_data.value_z;
               end
               tbb_pkg::CMD_SCALE: begin
                  scale_ff[0] <= req_data.value_x;
                  scale_ff[1] <= req_data.value_y;
                  scale_ff[2] <= req_data.value_z;
               end
               tbb_pkg::CMD_BOX_LOW: begin
                  low_ff[0] <= req_data.value_x;
                  low_ff[1] <= req_data.value_y;
                  low_ff[2] <= req_data.value_z;
               end
               tbb_pkg::CMD_BOX_HIGH: begin
                  high_ff[0] <= req_data.value_x;
                  high_ff[1] <= req_data.value_y;
                  high_ff[2] <= req_data.value_z;
               end
               tbb_pkg::CMD_COMPUTE: begin
                  state_ff <= S_TRIG;
               end
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
            end
            S_TRIG: begin
               if (lane_done[0]) begin
                  state_ff <= S_MAC;
                  step_ff  <= '0;
                  sub_ff   <= '0;
               end
            end
            S_MAC: begin
               if (sub_ff == 3'd4) begin
                  sub_ff <= '0;
                  if (step_ff == STEP_RADIUS) begin
                     state_ff     <= S_IDLE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     step_ff <= step_ff + 5'd1;
                  end
               end else begin
                  sub_ff <= sub_ff + 3'd1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result capture and box merge
   always_ff @(posedge clock) begin
      if (go) begin
         radius_ff <= req_data.value_x;
      end
      if (state_ff == S_MAC && sub_ff == 3'd4) begin
         for (int i = 0; i < 3; i++) begin
            priority if (step_ff < STEP_R) begin
               rxy_ff[i][col] <= acc[i];
            end else if (step_ff < STEP_CORNER) begin
               rm_ff[i][col] <= acc[i];
            end else if (step_ff == STEP_RADIUS) begin
               // radius comes from lane 0 only, captured below
            end else if (!cstep[0]) begin
               q_ff[i] <= acc[i];
            end else begin
               if (kk == 3'd0 || acc[i] < lo_ff[i]) begin
                  lo_ff[i] <= acc[i];
               end
               if (kk == 3'd0 || acc[i] > hi_ff[i]) begin
                  hi_ff[i] <= acc[i];
               end
            end
         end
         if (step_ff == STEP_RADIUS) begin
            rsp_ff.sphere_radius <= acc[0];
         end
         rsp_ff.box_min_x       <= lo_ff[0];
         rsp_ff.box_min_y       <= lo_ff[1];
         rsp_ff.box_min_z       <= lo_ff[2];
         rsp_ff.box_max_x       <= hi_ff[0];
         rsp_ff.box_max_y       <= hi_ff[1];
         rsp_ff.box_max_z       <= hi_ff[2];
         rsp_ff.sphere_center_x <= trans_ff[0];
         rsp_ff.sphere_center_y <= trans_ff[1];
         rsp_ff.sphere_center_z <= trans_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TBB_ASSERT_NOW(a_lanes_sync, clock, reset, lane_done[0], lane_done[1] && lane_done[2])
   `TBB_ASSERT_NEXT(a_go_busy, clock, reset, go, busy)
   `TBB_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `TBB_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)

endmodule

`default_nettype wire

### verif/transformed_bounds_builder_checker.sv
`timescale 1ns / 1ps

// Watches the request and response channels, predicts each compute result
// and compares it against what the block produces.
module transformed_bounds_builder_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire tbb_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire tbb_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    bounds_checked
);
   import tbb_pkg::*;

   // predicted object state, one word per axis
   longint trans_q[3];
   longint angle_q[3];
   longint scale_q[3];
   longint corner_lo_q[3];
   longint corner_hi_q[3];

   rsp_type bounds_queue[$];

   localparam longint MAX_W = 64'sd2147483647;
   localparam longint MIN_W = -64'sd2147483648;

   // Q16 product: magnitude truncated, sign applied, saturated
   function automatic longint q_mul(input longint a, input longint b);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] m;
      logic        neg;
      ua  = a < 0 ? 64'(-a) : 64'(a);
      ub  = b < 0 ? 64'(-b) : 64'(b);
      neg = (a < 0) != (b < 0);
      m   = (ua * ub) >> FRAC_BITS;
      if (neg) return (m > 64'd2147483648) ? MIN_W : -longint'(m);
      return (m > 64'd2147483647) ? MAX_W : longint'(m);
   endfunction

   function automatic longint q_add(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > MAX_W) return MAX_W;
      if (s < MIN_W) return MIN_W;
      return s;
   endfunction

   // CORDIC sine/cosine of an angle in Q16 degrees
   task automatic trig(input longint ang, output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      longint atan_tab[16];
      atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
      x    = 652032875;
      y    = 0;
      flip = 0;
      z    = ang % 23592960;
      if (z < 0) z += 23592960;
      if (z >= 11796480) z -= 23592960;
      if (z > 5898240) begin
         z    = 11796480 - z;
         flip = 1;
      end else if (z < -5898240) begin
         z    = -11796480 - z;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += atan_tab[i];
         end
         x = nx;
      end
      if (flip) x = -x;
      c = (x + 8192) >>> 14;
      s = (y + 8192) >>> 14;
   endtask

   function automatic void mat_product(input longint a[3][3], input longint b[3][3],
                                       output longint o[3][3]);
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc = q_add(acc, q_mul(a[i][k], b[k][j]));
            o[i][j] = acc;
         end
   endfunction

   // world box and bounding sphere for the stored object
   task automatic predict_bounds(input longint radius, output rsp_type r);
      longint sx, cx, sy, cy, sz, cz;
      longint rx[3][3];
      longint ry[3][3];
      longint rz[3][3];
      longint rxy[3][3];
      longint rot[3][3];
      longint lo[3];
      longint hi[3];
      longint q[3];
      longint w;
      longint smax;
      longint one;
      longint rad;
      one = longint'(ONE_Q);
      trig(angle_q[0], sx, cx);
      trig(angle_q[1], sy, cy);
      trig(angle_q[2], sz, cz);
      rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
      ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
      rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
      mat_product(rx, ry, rxy);
      mat_product(rxy, rz, rot);
      for (int k = 0; k < 8; k++) begin
         for (int j = 0; j < 3; j++)
            q[j] = q_mul(scale_q[j], ((k >> j) & 1) ? corner_hi_q[j] : corner_lo_q[j]);
         for (int i = 0; i < 3; i++) begin
            w = trans_q[i];
            for (int j = 0; j < 3; j++) w = q_add(w, q_mul(rot[i][j], q[j]));
            if (k == 0 || w < lo[i]) lo[i] = w;
            if (k == 0 || w > hi[i]) hi[i] = w;
         end
      end
      smax = scale_q[0];
      if (scale_q[1] > smax) smax = scale_q[1];
      if (scale_q[2] > smax) smax = scale_q[2];
      rad = q_mul(radius, smax);
      r.box_min_x       = lo[0][31:0];
      r.box_min_y       = lo[1][31:0];
      r.box_min_z       = lo[2][31:0];
      r.box_max_x       = hi[0][31:0];
      r.box_max_y       = hi[1][31:0];
      r.box_max_z       = hi[2][31:0];
      r.sphere_center_x = trans_q[0][31:0];
      r.sphere_center_y = trans_q[1][31:0];
      r.sphere_center_z = trans_q[2][31:0];
      r.sphere_radius   = rad[31:0];
   endtask

   assign pending_count = bounds_queue.size();

   // responses first, then the request accepted at the same edge
   always @(posedge clock) begin
      rsp_type     want;
      logic [31:0] gw;
      logic [31:0] ww;
      longint      v[3];
      bit          bad;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            trans_q[i]     = 0;
            angle_q[i]     = 0;
            scale_q[i]     = 0;
            corner_lo_q[i] = 0;
            corner_hi_q[i] = 0;
         end
         bounds_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (bounds_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %h", rsp_data);
            end else begin
               want = bounds_queue.pop_front();
               bad  = 0;
               for (int f = 0; f < 10; f++) begin
                  ww = want[319 - 32*f -: 32];
                  gw = rsp_data[319 - 32*f -: 32];
                  if (ww !== gw) begin
                     bad = 1;
                     if (fail_count < 10)
                        $display("response field %0d: expected %h, got %h", f, ww, gw);
                  end
               end
               if (bad) fail_count <= fail_count + 1;
               bounds_checked <= bounds_checked + 1;
            end
         end
         if (start && !busy) begin
            v[0] = longint'(req_data.value_x);
            v[1] = longint'(req_data.value_y);
            v[2] = longint'(req_data.value_z);
            case (req_data.command)
               CMD_TRANSLATION: trans_q     = v;
               CMD_ROTATION:    angle_q     = v;
               CMD_SCALE:       scale_q     = v;
               CMD_BOX_LOW:     corner_lo_q = v;
               CMD_BOX_HIGH:    corner_hi_q = v;
               CMD_COMPUTE: begin
                  predict_bounds(v[0], want);
                  bounds_queue.push_back(want);
               end
               default: ;
            endcase
         end
      end
   end

   initial begin
      fail_count     = 0;
      bounds_checked = 0;
   end

endmodule

### verif/tb_transformed_bounds_builder_core.sv
`timescale 1ns / 1ps

module tb_transformed_bounds_builder_core;
   import tbb_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT  = 2000000;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      bounds_checked;
   int      cycles = 0;
   int      requests_sent = 0;
   bit      gaps_on = 1;

   always #1 clock = ~clock;

   transformed_bounds_builder_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   transformed_bounds_builder_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .bounds_checked(bounds_checked)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // issue one request, wait for acceptance, then an optional gap
   task automatic send(input logic [2:0] cmd, input logic [31:0] x,
                       input logic [31:0] y, input logic [31:0] z);
      int gap;
      start    <= 1'b1;
      req_data <= '{command: cmd, value_x: x, value_y: y, value_z: z};
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random word: mostly modest Q16 values, sometimes extremes or raw bits
   function automatic logic [31:0] pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return $urandom();
         1:       return 32'h7fff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'($signed($urandom_range(0, 720)) - 360) << 16;
         default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      if ($urandom_range(0, 7) == 0) return pick_word();
      return $urandom_range(32'h0000_4000, 32'h0004_0000);
   endfunction

   initial begin
      logic [2:0] cmd;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity object, quadrant angles, extremes, spare commands
      send(CMD_COMPUTE, 32'h0001_0000, 0, 0);
      send(CMD_SCALE, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
      send(CMD_BOX_LOW, 32'h0001_0000, 32'hffff_0000, 32'h0003_0000);
      send(CMD_BOX_HIGH, 32'hffff_0000, 32'h0002_0000, 32'hfffd_0000);
      send(CMD_TRANSLATION, 32'h0010_0000, 32'hfff0_0000, 32'h0000_0001);
      send(CMD_ROTATION, 32'h005a_0000, 32'h00b4_0000, 32'h010e_0000);
      send(CMD_COMPUTE, 32'h0003_0000, 32'hffff_ffff, 32'hffff_ffff);
      send(CMD_ROTATION, 32'hffa6_0000, 32'h0168_0000, 32'hfe98_0000);
      send(CMD_COMPUTE, 32'hffff_0000, 0, 0);
      send(CMD_ROTATION, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      send(CMD_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send(CMD_SPARE_HI, 32'h1234_5678, 0, 0);
      send(CMD_COMPUTE, 32'h7fff_ffff, 0, 0);
      send(CMD_SCALE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send(CMD_BOX_LOW, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(CMD_BOX_HIGH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send(CMD_TRANSLATION, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send(CMD_COMPUTE, 32'h8000_0000, 0, 0);
      send(CMD_ROTATION, 32'h002d_0000, 32'h001e_8000, 32'hffc4_0000);
      send(CMD_COMPUTE, 32'h7fff_ffff, 0, 0);

      // random objects: five loads in random order then a compute,
      // with occasional noise and partial objects
      while (requests_sent < 1070) begin
         if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
         if ($urandom_range(0, 9) == 0) begin
            cmd = 3'($urandom_range(0, 7));
            send(cmd, $urandom(), $urandom(), $urandom());
         end else begin
            for (int n = 0; n < 5; n++) begin
               cmd = 3'($urandom_range(0, 4));
               if (cmd == CMD_SCALE)
                  send(cmd, pick_scale(), pick_scale(), pick_scale());
               else
                  send(cmd, pick_word(), pick_word(), pick_word());
            end
            send(CMD_COMPUTE, pick_word(), $urandom(), $urandom());
         end
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d requests; checked %0d bounds results over directed",
               requests_sent, bounds_checked);
      $display("quadrant/extreme angles, saturating sizes and random objects.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### transformed_bounds_builder_core.f
+incdir+rtl
rtl/tbb_pkg.sv
rtl/tbb_cordic_lane.sv
rtl/tbb_mac_lane.sv
rtl/transformed_bounds_builder_core.sv
verif/transformed_bounds_builder_checker.sv
verif/tb_transformed_bounds_builder_core.sv
